// File: src/ilsm_pkg.sv
// Shared constants and types of the inverse lifting subband merge.
`default_nettype none

package ilsm_pkg;

	// configuration port
	localparam int CFG_IDX_BITS  = 8;
	localparam int CFG_DATA_BITS = 13;

	localparam logic [CFG_IDX_BITS-1:0] REG_TILE_ROWS  = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TILE_COLS  = 8'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_TILE = 8'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LAST_TILE  = 8'd3;

	localparam int ROW_BITS = 12;
	localparam int COL_BITS = 12;

	// stencil operands: <row role>_<coef>_<column role>
	// row role C = row r, P = previous row, N = next row
	// column role C = c, P = c+1, M = c-1, MN = column after c-1
	localparam int OP_C_LH_C  = 0;
	localparam int OP_C_HH_C  = 1;
	localparam int OP_C_HH_P  = 2;
	localparam int OP_P_HH_C  = 3;
	localparam int OP_P_HH_P  = 4;
	localparam int OP_N_LH_C  = 5;
	localparam int OP_N_HH_C  = 6;
	localparam int OP_N_HH_P  = 7;
	localparam int OP_C_LH_M  = 8;
	localparam int OP_C_HH_M  = 9;
	localparam int OP_C_HH_MN = 10;
	localparam int OP_P_HH_M  = 11;
	localparam int OP_P_HH_MN = 12;
	localparam int OP_N_LH_M  = 13;
	localparam int OP_N_HH_M  = 14;
	localparam int OP_N_HH_MN = 15;
	localparam int OP_C_LL_C  = 16;
	localparam int OP_C_HL_C  = 17;
	localparam int OP_C_LL_P  = 18;
	localparam int OP_P_HL_C  = 19;
	localparam int OP_C_HL_M  = 20;
	localparam int OP_N_LL_C  = 21;
	localparam int OP_COUNT   = 22;

	// position tag that rides along with one result
	typedef struct packed {
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic                done;
	} pos_t;

endpackage

`default_nettype wire

// File: src/ilsm_if.sv
// Channel interfaces: coefficient input, result output, configuration writes.
`default_nettype none

interface ilsm_coef_if #(parameter int COEF_BITS = 24);
	logic                        valid;
	logic                        ready;
	logic signed [COEF_BITS-1:0] ll_coef;
	logic signed [COEF_BITS-1:0] lh_coef;
	logic signed [COEF_BITS-1:0] hh_coef;
	logic signed [COEF_BITS-1:0] hl_coef;

	modport source (output valid, ll_coef, lh_coef, hh_coef, hl_coef, input ready);
	modport sink (input valid, ll_coef, lh_coef, hh_coef, hl_coef, output ready);
endinterface

interface ilsm_result_if #(parameter int OUT_BITS = 26);
	logic                                valid;
	logic                                ready;
	logic signed [OUT_BITS-1:0]          low_value;
	logic signed [OUT_BITS-1:0]          high_value;
	logic [ilsm_pkg::ROW_BITS-1:0]       out_row;
	logic [ilsm_pkg::COL_BITS-1:0]       out_col;
	logic                                tile_done;

	modport source (output valid, low_value, high_value, out_row, out_col, tile_done,
		input ready);
	modport sink (input valid, low_value, high_value, out_row, out_col, tile_done,
		output ready);
endinterface

interface ilsm_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [ilsm_pkg::CFG_IDX_BITS-1:0]  index;
	logic [ilsm_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/ilsm_line_store.sv
// Line stores: previous row (all four coefficients) and the row before it (hh, hl).
`default_nettype none

module ilsm_line_store #(
	parameter int DEPTH = 4096,
	parameter int COEF_BITS = 24,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      rd_en,
	input  wire logic [AW-1:0]             rd_addr,
	input  wire logic [3:0][COEF_BITS-1:0] wr_data,
	input  wire logic                      b_wr_en,
	input  wire logic [AW-1:0]             b_wr_addr,
	input  wire logic [1:0][COEF_BITS-1:0] b_wr_data,
	output logic      [3:0][COEF_BITS-1:0] a_rd_data,
	output logic      [1:0][COEF_BITS-1:0] b_rd_data
);

	logic [3:0][COEF_BITS-1:0] a_mem [DEPTH];
	logic [1:0][COEF_BITS-1:0] b_mem [DEPTH];

	logic [1:0][COEF_BITS-1:0] b_rd_q;
	logic [1:0][COEF_BITS-1:0] fwd_data_q;
	logic                      fwd_q;

	// row store: read old word, then overwrite it with the new beat
	always_ff @(posedge clk) begin
		if (rd_en) begin
			a_rd_data <= a_mem[rd_addr];
			a_mem[rd_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			b_rd_q <= b_mem[rd_addr];
		if (b_wr_en)
			b_mem[b_wr_addr] <= b_wr_data;
	end

	// a write to the entry being read in the same cycle is bypassed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= b_wr_en && (b_wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			fwd_data_q <= b_wr_data;
	end

	assign b_rd_data = fwd_q ? fwd_data_q : b_rd_q;

endmodule

`default_nettype wire

// File: src/ilsm_stencil.sv
// Lifting arithmetic: three-stage pipeline from operand set to low/high values.
`default_nettype none

module ilsm_stencil #(
	parameter int COEF_BITS = 24
) (
	input  wire logic                                            clk,
	input  wire logic                                            arst_n,
	input  wire logic                                            in_valid,
	output logic                                                 in_ready,
	input  wire logic [ilsm_pkg::OP_COUNT-1:0][COEF_BITS-1:0]    in_ops,
	input  wire ilsm_pkg::pos_t                                  in_pos,
	output logic                                                 out_valid,
	input  wire logic                                            out_ready,
	output logic signed [COEF_BITS+1:0]                          out_low,
	output logic signed [COEF_BITS+1:0]                          out_high,
	output ilsm_pkg::pos_t                                       out_pos
);

	localparam int W = COEF_BITS;
	typedef logic signed [W+2:0] wide_t;

	wide_t ext [ilsm_pkg::OP_COUNT];

	always_comb begin
		for (int i = 0; i < ilsm_pkg::OP_COUNT; i++)
			ext[i] = wide_t'(signed'(in_ops[i]));
	end

	// handshake
	logic v3_q, v4_q, vo_q;
	logic rdy_o, rdy_4, rdy_3;

	assign rdy_o    = !vo_q || out_ready;
	assign rdy_4    = !v4_q || rdy_o;
	assign rdy_3    = !v3_q || rdy_4;
	assign in_ready = rdy_3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (rdy_3)
				v3_q <= in_valid;
			if (rdy_4)
				v4_q <= v3_q;
			if (rdy_o)
				vo_q <= v4_q;
		end
	end

	// stage 3: four-term sums
	logic signed [W+1:0] hpc_s3, hnc_s3, hpm_s3, hnm_s3, lsum_s3, hsum_s3;
	logic signed [W-1:0] lpc_s3, lnc_s3, lpm_s3, lnm_s3, hh_s3;
	ilsm_pkg::pos_t      pos_s3;

	always_ff @(posedge clk) begin
		if (rdy_3 && in_valid) begin
			hpc_s3  <= (W+2)'(ext[ilsm_pkg::OP_C_HH_C] + ext[ilsm_pkg::OP_C_HH_P]
				+ ext[ilsm_pkg::OP_P_HH_C] + ext[ilsm_pkg::OP_P_HH_P]);
			hnc_s3  <= (W+2)'(ext[ilsm_pkg::OP_C_HH_C] + ext[ilsm_pkg::OP_C_HH_P]
				+ ext[ilsm_pkg::OP_N_HH_C] + ext[ilsm_pkg::OP_N_HH_P]);
			hpm_s3  <= (W+2)'(ext[ilsm_pkg::OP_C_HH_M] + ext[ilsm_pkg::OP_C_HH_MN]
				+ ext[ilsm_pkg::OP_P_HH_M] + ext[ilsm_pkg::OP_P_HH_MN]);
			hnm_s3  <= (W+2)'(ext[ilsm_pkg::OP_C_HH_M] + ext[ilsm_pkg::OP_C_HH_MN]
				+ ext[ilsm_pkg::OP_N_HH_M] + ext[ilsm_pkg::OP_N_HH_MN]);
			lsum_s3 <= (W+2)'(ext[ilsm_pkg::OP_C_LL_C] + ext[ilsm_pkg::OP_C_HL_C]
				+ ext[ilsm_pkg::OP_C_LL_P] + ext[ilsm_pkg::OP_P_HL_C]);
			hsum_s3 <= (W+2)'(ext[ilsm_pkg::OP_C_LL_C] + ext[ilsm_pkg::OP_C_HL_C]
				+ ext[ilsm_pkg::OP_C_HL_M] + ext[ilsm_pkg::OP_N_LL_C]);
			lpc_s3  <= in_ops[ilsm_pkg::OP_C_LH_C];
			lnc_s3  <= in_ops[ilsm_pkg::OP_N_LH_C];
			lpm_s3  <= in_ops[ilsm_pkg::OP_C_LH_M];
			lnm_s3  <= in_ops[ilsm_pkg::OP_N_LH_M];
			hh_s3   <= in_ops[ilsm_pkg::OP_C_HH_C];
			pos_s3  <= in_pos;
		end
	end

	// stage 4: predictions, low value, high partial
	wide_t pc_w;
	assign pc_w = wide_t'(lpc_s3) - (wide_t'(hpc_s3) >>> 3);

	logic signed [W:0]   pc_s4, nc_s4, pm_s4, nm_s4, hsub_s4;
	logic signed [W+1:0] low_s4;
	ilsm_pkg::pos_t      pos_s4;

	always_ff @(posedge clk) begin
		if (rdy_4 && v3_q) begin
			pc_s4   <= (W+1)'(pc_w);
			nc_s4   <= (W+1)'(wide_t'(lnc_s3) - (wide_t'(hnc_s3) >>> 3));
			pm_s4   <= (W+1)'(wide_t'(lpm_s3) - (wide_t'(hpm_s3) >>> 3));
			nm_s4   <= (W+1)'(wide_t'(lnm_s3) - (wide_t'(hnm_s3) >>> 3));
			low_s4  <= (W+2)'(pc_w - (wide_t'(lsum_s3) >>> 3));
			hsub_s4 <= (W+1)'(wide_t'(hh_s3) - (wide_t'(hsum_s3) >>> 3));
			pos_s4  <= pos_s3;
		end
	end

	// output register
	wide_t psum;
	assign psum = wide_t'(pm_s4) + wide_t'(pc_s4) + wide_t'(nc_s4) + wide_t'(nm_s4);

	always_ff @(posedge clk) begin
		if (rdy_o && v4_q) begin
			out_low  <= low_s4;
			out_high <= (W+2)'(wide_t'(hsub_s4) + (psum >>> 2));
			out_pos  <= pos_s4;
		end
	end

	assign out_valid = vo_q;

endmodule

`default_nettype wire

// File: src/inverse_lifting_subband_merge.sv
// Inverse lifting subband merge: tile counters, line stores, column window, result issue.
// Usage:
//  - coef: one beat per tile position in raster order (ll, lh, hh, hl). A halo
//    row above comes first when first_tile is 0, a halo row below last when
//    last_tile is 0.
//  - result: low/high values with tile row, column and tile_done. A row is
//    delivered one row and one column behind the input.
//  - cfg: register writes (0 tile_rows, 1 tile_cols, 2 first_tile, 3 last_tile);
//    always ready, any valid index restarts the tile. Write only while idle.
// Throughput: one coefficient beat per cycle while each beat completes at most
// one result and result.ready is high. A beat that completes n > 1 results holds
// the input until all n have issued (up to two per beat on the last row of a
// last tile, up to four on its last column); the result port moves one beat
// per cycle, while result.ready is high, through the single stencil pipeline.
// Path: a result passes the line store read, column window, sum stage, prediction
// stage and output register after the beat that completes it.
// Reset: registers return to 1/1/1/1, counters to zero; line store contents are
// not cleared and need none. No clearing pass.
// When result.ready is low the pipeline fills and coef.ready drops; nothing is dropped.
`default_nettype none

module inverse_lifting_subband_merge #(
	parameter int MAX_COLS = 4096,
	parameter int COEF_BITS = 24
) (
	input wire logic       clk,
	input wire logic       arst_n,
	ilsm_coef_if.sink      coef,
	ilsm_result_if.source  result,
	ilsm_cfg_if.sink       cfg
);

	localparam int W  = COEF_BITS;
	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CW = $clog2(MAX_COLS + 1);

	// column vector: rows t-2 (B), t-1 (A) and t (X) at one column
	localparam int CV_B_HH = 0;
	localparam int CV_B_HL = 1;
	localparam int CV_A_LL = 2;
	localparam int CV_A_LH = 3;
	localparam int CV_A_HH = 4;
	localparam int CV_A_HL = 5;
	localparam int CV_X_LL = 6;
	localparam int CV_X_LH = 7;
	localparam int CV_X_HH = 8;
	localparam int CV_X_HL = 9;
	localparam int CV_N    = 10;

	localparam logic [1:0] ROW_B = 2'd0;
	localparam logic [1:0] ROW_A = 2'd1;
	localparam logic [1:0] ROW_X = 2'd2;

	typedef logic signed [W-1:0] coef_t;
	typedef coef_t [CV_N-1:0] colvec_t;

	function automatic coef_t prev_hh(input colvec_t v, input logic [1:0] src);
		unique case (src)
			ROW_B:   return v[CV_B_HH];
			ROW_A:   return v[CV_A_HH];
			default: return v[CV_X_HH];
		endcase
	endfunction

	function automatic coef_t prev_hl(input colvec_t v, input logic [1:0] src);
		unique case (src)
			ROW_B:   return v[CV_B_HL];
			ROW_A:   return v[CV_A_HL];
			default: return v[CV_X_HL];
		endcase
	endfunction

	function automatic coef_t cur_ll(input colvec_t v, input logic use_a);
		return use_a ? v[CV_A_LL] : v[CV_X_LL];
	endfunction

	function automatic coef_t cur_lh(input colvec_t v, input logic use_a);
		return use_a ? v[CV_A_LH] : v[CV_X_LH];
	endfunction

	function automatic coef_t cur_hh(input colvec_t v, input logic use_a);
		return use_a ? v[CV_A_HH] : v[CV_X_HH];
	endfunction

	function automatic coef_t cur_hl(input colvec_t v, input logic use_a);
		return use_a ? v[CV_A_HL] : v[CV_X_HL];
	endfunction

	// configuration
	logic [12:0]   tile_rows_q, tile_cols_q;
	logic          first_q, last_q;
	logic [12:0]   row_cnt_q;
	logic [AW-1:0] col_cnt_q;
	logic          cfg_hit;

	assign cfg.ready = 1'b1;

	always_comb begin
		unique case (cfg.index)
			ilsm_pkg::REG_TILE_ROWS,
			ilsm_pkg::REG_TILE_COLS,
			ilsm_pkg::REG_FIRST_TILE,
			ilsm_pkg::REG_LAST_TILE: cfg_hit = cfg.valid;
			default:                 cfg_hit = 1'b0;
		endcase
	end

	// tile shape
	logic [12:0]   rows;
	logic [CW-1:0] cols;
	logic          head;
	logic [13:0]   total;

	always_comb begin
		if (tile_rows_q == 13'd0)
			rows = 13'd1;
		else if (tile_rows_q > 13'd4096)
			rows = 13'd4096;
		else
			rows = tile_rows_q;
		if (tile_cols_q == 13'd0)
			cols = CW'(1);
		else if (32'(tile_cols_q) > 32'(MAX_COLS))
			cols = CW'(MAX_COLS);
		else
			cols = CW'(tile_cols_q);
	end

	assign head  = !first_q;
	assign total = 14'(rows) + 14'(head) + 14'(!last_q);

	// stage 0: position of the incoming beat
	logic          stale;
	logic [13:0]   rc;
	logic [AW-1:0] k;
	logic [CW-1:0] k_w, k_inc;
	logic          k_last, k_zero, k_one;
	logic          up_any, lo_any;
	logic [3:0]    jobs_in;
	logic [11:0]   r_lo, r_up;
	logic [13:0]   rc_inc;
	logic          accept;

	assign stale  = (14'(row_cnt_q) >= total) || (CW'(col_cnt_q) >= cols);
	assign rc     = stale ? 14'd0 : 14'(row_cnt_q);
	assign k      = stale ? '0 : col_cnt_q;
	assign k_w    = CW'(k);
	assign k_inc  = k_w + CW'(1);
	assign k_last = (k_w == cols - CW'(1));
	assign k_zero = (k_w == CW'(0));
	assign k_one  = (k_w == CW'(1));
	assign up_any = (rc >= 14'(head) + 14'd1) && (rc <= 14'(rows) + 14'(head));
	assign lo_any = last_q && (rc == 14'(rows) - 14'd1 + 14'(head));
	// bit order is emission order: row above k-1, k; own row k-1, k
	assign jobs_in = {lo_any && k_last, lo_any && !k_zero, up_any && k_last,
		up_any && !k_zero};
	assign r_lo   = 12'(rc - 14'(head));
	assign r_up   = r_lo - 12'd1;
	assign rc_inc = rc + 14'd1;

	// stage 1 / stage 2 handshake
	logic          v1_q, adv1;
	logic [3:0]    jobs_s2, sel, rem;
	logic          issue, st_ready, s2_free;

	assign sel     = jobs_s2 & (~jobs_s2 + 4'd1);
	assign issue   = (jobs_s2 != 4'd0) && st_ready;
	assign rem     = issue ? (jobs_s2 & ~sel) : jobs_s2;
	assign s2_free = (rem == 4'd0);
	assign adv1    = v1_q && s2_free;

	assign coef.ready = !v1_q || adv1;
	assign accept     = coef.valid && coef.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_rows_q <= 13'd1;
			tile_cols_q <= 13'd1;
			first_q     <= 1'b1;
			last_q      <= 1'b1;
			row_cnt_q   <= 13'd0;
			col_cnt_q   <= '0;
		end else if (cfg_hit) begin
			unique case (cfg.index)
				ilsm_pkg::REG_TILE_ROWS:  tile_rows_q <= cfg.data;
				ilsm_pkg::REG_TILE_COLS:  tile_cols_q <= cfg.data;
				ilsm_pkg::REG_FIRST_TILE: first_q <= cfg.data[0];
				ilsm_pkg::REG_LAST_TILE:  last_q <= cfg.data[0];
				default: ;
			endcase
			row_cnt_q <= 13'd0;
			col_cnt_q <= '0;
		end else if (accept) begin
			if (k_inc >= cols) begin
				col_cnt_q <= '0;
				row_cnt_q <= (rc_inc >= total) ? 13'd0 : 13'(rc_inc);
			end else begin
				col_cnt_q <= AW'(k_inc);
			end
		end
	end

	// line stores
	logic [3:0][W-1:0] wr_word, a_rd;
	logic [1:0][W-1:0] b_wr, b_rd;
	logic [AW-1:0]     k_s1;

	assign wr_word = {coef.hl_coef, coef.hh_coef, coef.lh_coef, coef.ll_coef};
	assign b_wr    = {a_rd[3], a_rd[2]};

	ilsm_line_store #(
		.DEPTH     (MAX_COLS),
		.COEF_BITS (COEF_BITS)
	) u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr   (k),
		.wr_data   (wr_word),
		.b_wr_en   (adv1),
		.b_wr_addr (k_s1),
		.b_wr_data (b_wr),
		.a_rd_data (a_rd),
		.b_rd_data (b_rd)
	);

	// stage 1 registers
	logic [3:0][W-1:0] x_s1;
	logic [3:0]        jobs_s1;
	logic              kzero_s1, kone_s1, upfirst_s1, lofirst_s1, updone_s1;
	logic [11:0]       rup_s1, rlo_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v1_q <= 1'b0;
		else if (accept)
			v1_q <= 1'b1;
		else if (adv1)
			v1_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1       <= wr_word;
			k_s1       <= k;
			jobs_s1    <= jobs_in;
			kzero_s1   <= k_zero;
			kone_s1    <= k_one;
			upfirst_s1 <= first_q && (rc == 14'd1);
			lofirst_s1 <= first_q && (rc == 14'd0);
			updone_s1  <= (rc == 14'(rows) + 14'(head));
			rup_s1     <= r_up;
			rlo_s1     <= r_lo;
		end
	end

	colvec_t v1;

	always_comb begin
		v1[CV_B_HH] = b_rd[0];
		v1[CV_B_HL] = b_rd[1];
		v1[CV_A_LL] = a_rd[0];
		v1[CV_A_LH] = a_rd[1];
		v1[CV_A_HH] = a_rd[2];
		v1[CV_A_HL] = a_rd[3];
		v1[CV_X_LL] = x_s1[0];
		v1[CV_X_LH] = x_s1[1];
		v1[CV_X_HH] = x_s1[2];
		v1[CV_X_HL] = x_s1[3];
	end

	// stage 2: column window k-2, k-1, k
	colvec_t       w0_s2, w1_s2, w2_s2;
	logic [AW-1:0] k_s2;
	logic          kzero_s2, kone_s2, upfirst_s2, lofirst_s2, updone_s2;
	logic [11:0]   rup_s2, rlo_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			jobs_s2 <= 4'd0;
		else if (adv1)
			jobs_s2 <= jobs_s1;
		else
			jobs_s2 <= rem;
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			w0_s2      <= w1_s2;
			w1_s2      <= w2_s2;
			w2_s2      <= v1;
			k_s2       <= k_s1;
			kzero_s2   <= kzero_s1;
			kone_s2    <= kone_s1;
			upfirst_s2 <= upfirst_s1;
			lofirst_s2 <= lofirst_s1;
			updone_s2  <= updone_s1;
			rup_s2     <= rup_s1;
			rlo_s2     <= rlo_s1;
		end
	end

	// operand selection for the job being issued
	logic                                  upper, colk;
	logic [1:0]                            psrc;
	colvec_t                               cm, cmn, cc, cp;
	logic [ilsm_pkg::OP_COUNT-1:0][W-1:0]  ops;
	ilsm_pkg::pos_t                        pos;

	assign upper = sel[0] || sel[1];
	assign colk  = sel[1] || sel[3];

	always_comb begin
		if (upper)
			psrc = upfirst_s2 ? ROW_A : ROW_B;
		else
			psrc = lofirst_s2 ? ROW_X : ROW_A;

		// column c-1 at c == 0 is c itself; its right neighbour is then c+1
		if (colk) begin
			cc  = w2_s2;
			cp  = w2_s2;
			cm  = kzero_s2 ? w2_s2 : w1_s2;
			cmn = w2_s2;
		end else begin
			cc  = w1_s2;
			cp  = w2_s2;
			cm  = kone_s2 ? w1_s2 : w0_s2;
			cmn = kone_s2 ? w2_s2 : w1_s2;
		end

		ops[ilsm_pkg::OP_C_LH_C]  = cur_lh(cc, upper);
		ops[ilsm_pkg::OP_C_HH_C]  = cur_hh(cc, upper);
		ops[ilsm_pkg::OP_C_HH_P]  = cur_hh(cp, upper);
		ops[ilsm_pkg::OP_P_HH_C]  = prev_hh(cc, psrc);
		ops[ilsm_pkg::OP_P_HH_P]  = prev_hh(cp, psrc);
		ops[ilsm_pkg::OP_N_LH_C]  = cc[CV_X_LH];
		ops[ilsm_pkg::OP_N_HH_C]  = cc[CV_X_HH];
		ops[ilsm_pkg::OP_N_HH_P]  = cp[CV_X_HH];
		ops[ilsm_pkg::OP_C_LH_M]  = cur_lh(cm, upper);
		ops[ilsm_pkg::OP_C_HH_M]  = cur_hh(cm, upper);
		ops[ilsm_pkg::OP_C_HH_MN] = cur_hh(cmn, upper);
		ops[ilsm_pkg::OP_P_HH_M]  = prev_hh(cm, psrc);
		ops[ilsm_pkg::OP_P_HH_MN] = prev_hh(cmn, psrc);
		ops[ilsm_pkg::OP_N_LH_M]  = cm[CV_X_LH];
		ops[ilsm_pkg::OP_N_HH_M]  = cm[CV_X_HH];
		ops[ilsm_pkg::OP_N_HH_MN] = cmn[CV_X_HH];
		ops[ilsm_pkg::OP_C_LL_C]  = cur_ll(cc, upper);
		ops[ilsm_pkg::OP_C_HL_C]  = cur_hl(cc, upper);
		ops[ilsm_pkg::OP_C_LL_P]  = cur_ll(cp, upper);
		ops[ilsm_pkg::OP_P_HL_C]  = prev_hl(cc, psrc);
		ops[ilsm_pkg::OP_C_HL_M]  = cur_hl(cm, upper);
		ops[ilsm_pkg::OP_N_LL_C]  = cc[CV_X_LL];

		pos.row  = upper ? rup_s2 : rlo_s2;
		pos.col  = colk ? 12'(k_s2) : 12'(k_s2 - AW'(1));
		pos.done = sel[1] ? updone_s2 : sel[3];
	end

	ilsm_pkg::pos_t out_pos;

	ilsm_stencil #(
		.COEF_BITS (COEF_BITS)
	) u_stencil (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (jobs_s2 != 4'd0),
		.in_ready  (st_ready),
		.in_ops    (ops),
		.in_pos    (pos),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_low   (result.low_value),
		.out_high  (result.high_value),
		.out_pos   (out_pos)
	);

	assign result.out_row   = out_pos.row;
	assign result.out_col   = out_pos.col;
	assign result.tile_done = out_pos.done;

endmodule

`default_nettype wire

// File: dv/ilsm_tb_if.sv
// Testbench package: payload widths of the channel interfaces.
`timescale 1ns / 100ps

package ilsm_tb_pkg;
	localparam int TB_COEF_BITS = 24;
	localparam int TB_OUT_BITS  = 26;
endpackage

// File: dv/inverse_lifting_subband_merge_tb.sv
// Self-checking testbench of the inverse lifting subband merge.
`timescale 1ns / 100ps

module inverse_lifting_subband_merge_tb;

	typedef struct {
		logic signed [25:0] low_v;
		logic signed [25:0] high_v;
		logic [11:0]        row;
		logic [11:0]        col;
		logic               done;
	} merged_t;

	typedef struct {
		longint ll, lh, hh, hl;
	} quad_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ilsm_coef_if #(.COEF_BITS(ilsm_tb_pkg::TB_COEF_BITS)) coef ();
	ilsm_result_if #(.OUT_BITS(ilsm_tb_pkg::TB_OUT_BITS)) result ();
	ilsm_cfg_if cfg ();

	inverse_lifting_subband_merge u_top (
		.clk(clk), .arst_n(arst_n), .coef(coef), .result(result), .cfg(cfg)
	);

	// predictor state
	quad_t   lines [3][4096];
	int      in_row, in_col;
	int      rows_q, cols_q, first_q, last_q;
	merged_t pending_q[$];
	int      err_cnt = 0;
	int      beats_in = 0, results_seen = 0;
	bit      hold_off = 0;
	bit      draining = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic longint fshr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic int eff_rows();
		return rows_q == 0 ? 1 : (rows_q > 4096 ? 4096 : rows_q);
	endfunction

	function automatic int eff_cols();
		return cols_q == 0 ? 1 : (cols_q > 4096 ? 4096 : cols_q);
	endfunction

	function automatic int slot(int r);
		return (r + 1) % 3;
	endfunction

	function automatic void lift_pred(int pr, int r, int nr, int x, int cols,
		output longint p, output longint n);
		int xp;
		longint hs;
		xp = (x + 1 >= cols) ? x : x + 1;
		hs = lines[slot(r)][x].hh + lines[slot(r)][xp].hh;
		p = lines[slot(r)][x].lh - fshr(hs + lines[slot(pr)][x].hh + lines[slot(pr)][xp].hh, 3);
		n = lines[slot(nr)][x].lh - fshr(hs + lines[slot(nr)][x].hh + lines[slot(nr)][xp].hh, 3);
	endfunction

	function automatic void merge_pos(int r, int c, int rows, int cols);
		int pr, nr, cp, cm;
		longint pc, nc, pm, nm, s, lv, hv;
		merged_t m;
		pr = (r == 0 && first_q) ? 0 : r - 1;
		nr = (r == rows - 1 && last_q) ? r : r + 1;
		cp = (c + 1 >= cols) ? c : c + 1;
		cm = (c == 0) ? 0 : c - 1;
		lift_pred(pr, r, nr, c, cols, pc, nc);
		lift_pred(pr, r, nr, cm, cols, pm, nm);
		s = lines[slot(r)][c].ll + lines[slot(r)][c].hl;
		lv = pc - fshr(s + lines[slot(r)][cp].ll + lines[slot(pr)][c].hl, 3);
		hv = lines[slot(r)][c].hh - fshr(s + lines[slot(r)][cm].hl + lines[slot(nr)][c].ll, 3)
			+ fshr(pm + pc + nc + nm, 2);
		m.low_v = lv[25:0];
		m.high_v = hv[25:0];
		m.row = r[11:0];
		m.col = c[11:0];
		m.done = (r == rows - 1 && c == cols - 1);
		pending_q.push_back(m);
	endfunction

	function automatic void merge_row(int r, int k, int rows, int cols);
		if (k >= 1) merge_pos(r, k - 1, rows, cols);
		if (k == cols - 1) merge_pos(r, cols - 1, rows, cols);
	endfunction

	function automatic void predict_beat(logic [23:0] ll, logic [23:0] lh,
		logic [23:0] hh, logic [23:0] hl);
		int rows, cols, head, total, t;
		rows = eff_rows();
		cols = eff_cols();
		head = first_q ? 0 : 1;
		total = rows + head + (last_q ? 0 : 1);
		if (in_row >= total || in_col >= cols) begin
			in_row = 0;
			in_col = 0;
		end
		t = in_row - head;
		lines[slot(t)][in_col].ll = longint'($signed(ll));
		lines[slot(t)][in_col].lh = longint'($signed(lh));
		lines[slot(t)][in_col].hh = longint'($signed(hh));
		lines[slot(t)][in_col].hl = longint'($signed(hl));
		if (t >= 1 && t <= rows) merge_row(t - 1, in_col, rows, cols);
		if (last_q && t == rows - 1) merge_row(t, in_col, rows, cols);
		in_col++;
		if (in_col >= cols) begin
			in_col = 0;
			in_row++;
			if (in_row >= total) in_row = 0;
		end
	endfunction

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		merged_t e;
		if (arst_n && result.valid && result.ready) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				$error("result beat with nothing expected: row %0d col %0d",
					result.out_row, result.out_col);
				err_cnt++;
			end else begin
				e = pending_q.pop_front();
				if (result.low_value !== e.low_v) begin
					$error("low_value exp %0d got %0d", e.low_v, result.low_value);
					err_cnt++;
				end
				if (result.high_value !== e.high_v) begin
					$error("high_value exp %0d got %0d", e.high_v, result.high_value);
					err_cnt++;
				end
				if (result.out_row !== e.row) begin
					$error("out_row exp %0d got %0d", e.row, result.out_row);
					err_cnt++;
				end
				if (result.out_col !== e.col) begin
					$error("out_col exp %0d got %0d", e.col, result.out_col);
					err_cnt++;
				end
				if (result.tile_done !== e.done) begin
					$error("tile_done exp %0d got %0d", e.done, result.tile_done);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		int ph;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			ph = (ph + 1) % 64;
			if (hold_off) result.ready <= 1'b0;
			else if (draining || ph < 20) result.ready <= 1'b1;
			else result.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_beat(logic [23:0] ll, logic [23:0] lh, logic [23:0] hh,
		logic [23:0] hl);
		coef.valid <= 1'b1;
		coef.ll_coef <= ll;
		coef.lh_coef <= lh;
		coef.hh_coef <= hh;
		coef.hl_coef <= hl;
		@(posedge clk);
		while (!coef.ready) @(posedge clk);
		predict_beat(ll, lh, hh, hl);
		beats_in++;
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (g > 0) begin
			coef.valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic wait_empty();
		int n;
		coef.valid <= 1'b0;
		draining = 1;
		n = 0;
		while (pending_q.size() != 0 && n < 100000) begin
			@(negedge clk);
			n++;
		end
		repeat (10) @(negedge clk);
		draining = 0;
	endtask

	task automatic write_reg(logic [ilsm_pkg::CFG_IDX_BITS-1:0] idx, int val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val[12:0];
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			ilsm_pkg::REG_TILE_ROWS: rows_q = val & 13'h1fff;
			ilsm_pkg::REG_TILE_COLS: cols_q = val & 13'h1fff;
			ilsm_pkg::REG_FIRST_TILE: first_q = val & 1;
			ilsm_pkg::REG_LAST_TILE: last_q = val & 1;
			default: ;
		endcase
		if (idx <= ilsm_pkg::REG_LAST_TILE) begin
			in_row = 0;
			in_col = 0;
		end
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_shape(int r, int c, int f, int l);
		wait_empty();
		write_reg(ilsm_pkg::REG_TILE_ROWS, r);
		write_reg(ilsm_pkg::REG_TILE_COLS, c);
		write_reg(ilsm_pkg::REG_FIRST_TILE, f);
		write_reg(ilsm_pkg::REG_LAST_TILE, l);
	endtask

	function automatic logic [23:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return 24'h800000;
			1: return 24'h7fffff;
			2: return 24'(signed'($urandom_range(0, 16)) - 8);
			default: return 24'($urandom);
		endcase
	endfunction

	// send whole tiles: halo rows included
	task automatic run_tile(int mode);
		int n;
		n = (eff_rows() + (first_q ? 0 : 1) + (last_q ? 0 : 1)) * eff_cols();
		repeat (n) begin
			if (mode == 1)
				send_beat(rand_coef(), rand_coef(), rand_coef(), rand_coef());
			else
				send_beat(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
			idle_gap();
		end
	endtask

	typedef struct {
		logic [23:0] ll, lh, hh, hl;
		bit          chk;
		int          exp_low, exp_high;
	} stim_row_t;

	// typed values hold for a 1x1 tile, where every neighbor is the position itself
	stim_row_t directed_rows [8] = '{
		'{24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b1, 1, 8388608},
		'{24'h800000, 24'h800000, 24'h800000, 24'h800000, 1'b1, 0, -8388608},
		'{24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1, 0, 0},
		'{24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 1'b1, 1, 0},
		'{24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 1'b0, 0, 0},
		'{24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 1'b0, 0, 0},
		'{24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa, 1'b0, 0, 0},
		'{24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555, 1'b0, 0, 0}
	};

	initial begin
		int i, tiles;
		merged_t m;
		coef.valid = 1'b0;
		coef.ll_coef = '0;
		coef.lh_coef = '0;
		coef.hh_coef = '0;
		coef.hl_coef = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		rows_q = 1; cols_q = 1; first_q = 1; last_q = 1;
		in_row = 0; in_col = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// 1x1 tile after reset: each beat yields one result of its own
		for (i = 0; i < 4; i++) begin
			send_beat(directed_rows[i].ll, directed_rows[i].lh, directed_rows[i].hh,
				directed_rows[i].hl);
			if (directed_rows[i].chk) begin
				m = pending_q.pop_back();
				m.low_v = 26'(directed_rows[i].exp_low);
				m.high_v = 26'(directed_rows[i].exp_high);
				pending_q.push_back(m);
			end
		end
		// 2x2 tile with both halos, then zero sizes and an unknown index
		set_shape(2, 2, 0, 0);
		for (i = 0; i < 8; i++)
			send_beat(directed_rows[i].ll, directed_rows[i].lh, directed_rows[i].hh,
				directed_rows[i].hl);
		for (i = 0; i < 8; i++)
			send_beat(directed_rows[i].ll, directed_rows[i].lh, directed_rows[i].hh,
				directed_rows[i].hl);
		set_shape(0, 0, 1, 1);
		write_reg(8'd9, 5);
		send_beat(24'h123456, 24'h800000, 24'h7fffff, 24'hfedcba);

		// random tiles over several shapes, long stall once
		tiles = 0;
		while (beats_in < 100) begin
			case (tiles % 5)
				0: set_shape($urandom_range(1, 4), $urandom_range(1, 5), 1, 1);
				1: set_shape($urandom_range(1, 3), $urandom_range(2, 6), 0, 1);
				2: set_shape($urandom_range(1, 3), $urandom_range(1, 4), 1, 0);
				3: set_shape($urandom_range(2, 3), $urandom_range(2, 5), 0, 0);
				default: set_shape(1, 8191, 1, 1);
			endcase
			if (tiles == 2) begin
				// tile big enough that the input backs up behind the stalled output
				set_shape(3, 6, 1, 0);
				fork
					begin
						hold_off = 1;
						repeat (200) @(negedge clk);
						hold_off = 0;
					end
				join_none
			end
			if (cols_q == 8191) begin
				for (i = 0; i < 6; i++)
					send_beat(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
				// partial tile; restart via config write
			end else begin
				run_tile(tiles % 2);
			end
			tiles++;
		end
		wait_empty();
		$display("Covered %0d coefficient beats and %0d result beats over %0d tiles.",
			beats_in, results_seen, tiles);
		if (err_cnt == 0 && pending_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
